[rtl/oook_pkg.sv]
`default_nettype none
package oook_pkg;

    localparam int LEVEL_BITS    = 10;
    localparam int BITS_PER_CHAR = 7;
    localparam int CHAR_W        = 7;
    localparam int THR_W         = 11;
    localparam int OFFSET_W      = 10;
    localparam int TICK_W        = 16;
    localparam int END_CNT_W     = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_CHAR + 1);
    // Sample minus offset, with headroom for the sign and the clamp test.
    localparam int CAL_W         = (LEVEL_BITS > THR_W ? LEVEL_BITS : THR_W) + 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_INIT_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_OFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_TICKS = 3'd4;

    // Reset values of the registers.
    localparam logic signed [THR_W-1:0] INIT_THR_RST  = 11'sd512;
    localparam logic [OFFSET_W-1:0]     OFFSET_RST    = 10'd20;
    localparam logic [TICK_W-1:0]       PERIOD_RST    = 16'd100;
    localparam logic [TICK_W-1:0]       SYNC_OFF_RST  = 16'd998;
    localparam logic [TICK_W-1:0]       END_TICKS_RST = 16'd2000;

    // Result kinds.
    localparam logic KIND_SYNC = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] light_level;
        logic                  button_pressed;
    } item_t;

    typedef struct packed {
        logic                  result_kind;
        logic [CHAR_W-1:0]     char_value;
        logic                  message_end;
    } result_t;

    typedef struct packed {
        logic signed [THR_W-1:0] init_thr;
        logic [OFFSET_W-1:0]     offset;
        logic [TICK_W-1:0]       period;
        logic [TICK_W-1:0]       sync_off;
        logic [TICK_W-1:0]       end_ticks;
        logic                    thr_load;
    } cfg_t;

endpackage
`default_nettype wire

[rtl/optical_ook_char_receiver_core.sv]
// On-off-keyed light receiver with synchronization.
// Input channel (s_valid/s_ready): one item per sensor tick, carrying the light
// sample and the calibration button flag. Result channel (m_valid/m_ready):
// a sync result once the off hold completes, then one item per received
// character with its end-of-message flag. Most ticks produce no result.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata only
// while the block is idle; the block itself does not enforce this. Writing
// the initial threshold also reloads the working threshold. An accepted item
// is held in the input register and processed once the output slot is free
// or being emptied; its result is loaded into the output register at that
// edge. One item is taken every cycle while the result channel does not
// stall; the per-tick compares and counter updates lie between the registers.
// When the receiver holds m_ready low with a result waiting, the processing
// step stalls, the input register fills, and s_ready drops until the result
// is taken. A synchronous active-low reset returns the block to waiting for
// light on, restores the register defaults and empties both registers.
`default_nettype none
module optical_ook_char_receiver_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [oook_pkg::LEVEL_BITS-1:0]  s_light_level,
    input  wire logic                             s_button_pressed,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_result_kind,
    output logic [oook_pkg::CHAR_W-1:0]           m_char_value,
    output logic                                  m_message_end,
    input  wire logic                             cfg_we,
    input  wire logic [oook_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [oook_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import oook_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    step;
    logic    res_valid;
    result_t res;

    oook_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Process the held item whenever the output slot is free or being emptied.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    oook_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (step),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.light_level    <= s_light_level;
            in_item_reg.button_pressed <= s_button_pressed;
        end
        if (step && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_res_reg.result_kind;
    assign m_char_value  = out_res_reg.char_value;
    assign m_message_end = out_res_reg.message_end;

endmodule
`default_nettype wire

[rtl/oook_cfg.sv]
`default_nettype none
module oook_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [oook_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [oook_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output oook_pkg::cfg_t                        cfg
);
    import oook_pkg::*;

    logic signed [THR_W-1:0] init_thr_reg;
    logic [OFFSET_W-1:0]     offset_reg;
    logic [TICK_W-1:0]       period_reg;
    logic [TICK_W-1:0]       sync_off_reg;
    logic [TICK_W-1:0]       end_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_thr_reg  <= INIT_THR_RST;
            offset_reg    <= OFFSET_RST;
            period_reg    <= PERIOD_RST;
            sync_off_reg  <= SYNC_OFF_RST;
            end_ticks_reg <= END_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_INIT_THR:  init_thr_reg  <= signed'(cfg_wdata[THR_W-1:0]);
                REG_OFFSET:    offset_reg    <= cfg_wdata[OFFSET_W-1:0];
                REG_PERIOD:    period_reg    <= cfg_wdata[TICK_W-1:0];
                REG_SYNC_OFF:  sync_off_reg  <= cfg_wdata[TICK_W-1:0];
                REG_END_TICKS: end_ticks_reg <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // A threshold write also reloads the working threshold, in the same edge.
    always_comb begin
        cfg.init_thr  = (cfg_we && cfg_index == REG_INIT_THR)
                        ? signed'(cfg_wdata[THR_W-1:0]) : init_thr_reg;
        cfg.thr_load  = cfg_we && (cfg_index == REG_INIT_THR);
        cfg.offset    = offset_reg;
        cfg.period    = period_reg;
        cfg.sync_off  = sync_off_reg;
        cfg.end_ticks = end_ticks_reg;
    end

endmodule
`default_nettype wire

[rtl/oook_core.sv]
`default_nettype none
module oook_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire oook_pkg::cfg_t  cfg,
    input  wire logic            step,
    input  wire oook_pkg::item_t item,
    output logic                 res_valid,
    output oook_pkg::result_t    res
);
    import oook_pkg::*;

    typedef enum logic [1:0] {
        WAIT_ON,
        WAIT_OFF,
        HOLD_OFF,
        RECEIVING
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic signed [THR_W-1:0]  thr_reg, thr_next;
    logic [TICK_W-1:0]        off_cnt_reg, off_cnt_next;
    logic [TICK_W-1:0]        countdown_reg, countdown_next;
    logic [BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [BITS_PER_CHAR-1:0] shift_reg, shift_next;
    logic                     end_act_reg, end_act_next;
    logic [END_CNT_W-1:0]     end_cnt_reg, end_cnt_next;

    logic signed [CAL_W-1:0]  cal;
    logic signed [CAL_W-1:0]  level_s;
    logic                     on;
    logic [END_CNT_W-1:0]     end_cnt_run;
    logic [BIT_CNT_W-1:0]     bit_cnt_inc;
    logic [BITS_PER_CHAR-1:0] shift_inc;

    localparam logic signed [CAL_W-1:0] THR_MAX = CAL_W'(2 ** (THR_W - 1) - 1);
    localparam logic signed [CAL_W-1:0] THR_MIN = -CAL_W'(2 ** (THR_W - 1));

    always_comb begin
        phase_next     = phase_reg;
        thr_next       = thr_reg;
        off_cnt_next   = off_cnt_reg;
        countdown_next = countdown_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        end_act_next   = end_act_reg;
        end_cnt_next   = end_cnt_reg;
        res_valid      = 1'b0;
        res            = '0;

        level_s = signed'(CAL_W'(item.light_level));
        cal     = level_s - signed'(CAL_W'(cfg.offset));

        // Calibration is only honored before the off hold starts.
        if ((phase_reg == WAIT_ON || phase_reg == WAIT_OFF) && item.button_pressed) begin
            if (cal > THR_MAX) begin
                thr_next = THR_MAX[THR_W-1:0];
            end else if (cal < THR_MIN) begin
                thr_next = THR_MIN[THR_W-1:0];
            end else begin
                thr_next = cal[THR_W-1:0];
            end
        end
        on = level_s > CAL_W'(thr_next);

        end_cnt_run = end_cnt_reg;
        if (end_act_reg && end_cnt_reg != {END_CNT_W{1'b1}}) begin
            end_cnt_run = end_cnt_reg + 1'b1;
        end
        bit_cnt_inc = bit_cnt_reg + 1'b1;
        shift_inc   = {shift_reg[BITS_PER_CHAR-2:0], on};

        case (phase_reg)
            WAIT_ON: begin
                if (on) begin
                    phase_next = WAIT_OFF;
                end
            end
            WAIT_OFF, HOLD_OFF: begin
                if (on) begin
                    phase_next = WAIT_OFF;
                end else begin
                    if (phase_reg == WAIT_OFF) begin
                        phase_next   = HOLD_OFF;
                        off_cnt_next = '0;
                    end else if (off_cnt_reg != {TICK_W{1'b1}}) begin
                        off_cnt_next = off_cnt_reg + 1'b1;
                    end
                    if (off_cnt_next >= cfg.sync_off) begin
                        phase_next     = RECEIVING;
                        countdown_next = cfg.period >> 1;
                        bit_cnt_next   = '0;
                        shift_next     = '0;
                        res_valid      = 1'b1;
                        res.result_kind = KIND_SYNC;
                    end
                end
            end
            RECEIVING: begin
                end_cnt_next = end_cnt_run;
                if (countdown_reg > TICK_W'(1)) begin
                    countdown_next = countdown_reg - 1'b1;
                end else begin
                    countdown_next = cfg.period;
                    shift_next     = shift_inc;
                    bit_cnt_next   = bit_cnt_inc;
                    // The last bit's sample doubles as the end-of-message check.
                    if (bit_cnt_inc >= BIT_CNT_W'(BITS_PER_CHAR)) begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_CHAR;
                        res.char_value  = CHAR_W'(shift_inc);
                        if (on) begin
                            if (!end_act_reg) begin
                                end_act_next = 1'b1;
                                end_cnt_next = '0;
                            end
                            res.message_end = end_cnt_next > END_CNT_W'(cfg.end_ticks);
                        end else begin
                            end_act_next = 1'b0;
                            end_cnt_next = '0;
                        end
                        bit_cnt_next = '0;
                        shift_next   = '0;
                    end
                end
            end
            default: phase_next = WAIT_ON;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= WAIT_ON;
            thr_reg       <= INIT_THR_RST;
            off_cnt_reg   <= '0;
            countdown_reg <= '0;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            end_act_reg   <= 1'b0;
            end_cnt_reg   <= '0;
        end else if (cfg.thr_load) begin
            thr_reg <= cfg.init_thr;
        end else if (step) begin
            phase_reg     <= phase_next;
            thr_reg       <= thr_next;
            off_cnt_reg   <= off_cnt_next;
            countdown_reg <= countdown_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            end_act_reg   <= end_act_next;
            end_cnt_reg   <= end_cnt_next;
        end
    end

endmodule
`default_nettype wire
